[rtl/core/quadratic_probe_hash_table_core_macros.svh]
// Assertion helpers for the hash table core.
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qpht same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qpht next-cycle check failed");

`endif

[rtl/core/qpht_pkg.sv]
`default_nettype none
package qpht_pkg;

    localparam int TABLE_SIZE_DEF = 16;

    localparam int KEY_W    = 31;
    localparam int WORD_W   = 32;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    // Stream packing
    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = OP_W;
    localparam int OUT_TDATA_W = 16;

    // Key residue unit: key padded to whole digits, one digit per cycle
    localparam int KEY_PAD_W  = 32;
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = KEY_PAD_W / MOD_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_UPDATED   = 3'd1,
        STS_DELETED   = 3'd2,
        STS_FULL      = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_BAD       = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

[rtl/core/qpht_mod_unit.sv]
`default_nettype none
// Key mod TABLE_SIZE, MSB first, MOD_BITS key bits per cycle.
module qpht_mod_unit #(
    parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [qpht_pkg::KEY_W-1:0]    i_key,
    output logic                               o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_rem
);
    import qpht_pkg::*;

    localparam int RW    = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(MOD_CYCLES);
    localparam logic [RW:0]      N_C    = (RW+1)'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_CYCLES - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [KEY_PAD_W-1:0]  r_shift;
    logic [RW-1:0]         r_rem;
    logic [RW-1:0]         n_rem;

    // one compare-subtract per key bit
    always_comb begin
        logic [RW:0] t;
        n_rem = r_rem;
        for (int j = 0; j < MOD_BITS; j++) begin
            t = {n_rem, r_shift[KEY_PAD_W-1-j]};
            if (t >= N_C) begin
                t = t - N_C;
            end
            n_rem = t[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= KEY_PAD_W'(i_key);
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << MOD_BITS;
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

[rtl/core/quadratic_probe_hash_table_core.sv]
`default_nettype none
// Open-addressed hash table with quadratic probing. Each of TABLE_SIZE slots holds a
// 31-bit key and two 32-bit payload words; a key of zero means empty, and every slot
// is empty after reset (per-slot valid flops, no clearing pass). A request is one
// transaction on s_axis (op in tuser: insert, update, delete) and yields exactly one
// status transaction on m_axis. Probing visits (home + i*i) mod TABLE_SIZE for
// i = 0..TABLE_SIZE-1, home = key mod TABLE_SIZE. Insert takes the first empty probed
// slot without checking for duplicates; update and delete act on the first probed
// slot whose key matches. A zero key or the reserved op returns bad-key at once.
// One request at a time. A valid request is accepted, passes through the residue
// unit (4 key bits per cycle) until its done flag, then makes one registered key-memory
// read per probe, at most TABLE_SIZE probes, and then posts its result; fewer probes
// are made when an early probe hits. A bad request skips hashing and probing. The next
// request is taken while the previous result still waits in the output register.
`include "quadratic_probe_hash_table_core_macros.svh"
module quadratic_probe_hash_table_core #(
    parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // key[30:0], name_code[62:31], detail_code[94:63], zero fill [95]
    input  wire logic [qpht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  wire logic [qpht_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status[2:0], slot[10:3], zero fill [15:11]
    output logic [qpht_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import qpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W:0] N_C      = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [IDX_W:0] CNT_LAST = (IDX_W+1)'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] D_INIT = IDX_W'(1);

    // ---------------------------------------------------------------
    // request fields
    // ---------------------------------------------------------------
    logic [KEY_W-1:0]  in_key;
    logic [WORD_W-1:0] in_name;
    logic [WORD_W-1:0] in_detail;
    t_op               in_op;
    logic              in_accept;
    logic              in_bad;

    assign in_key    = s_axis_tdata[KEY_W-1:0];
    assign in_name   = s_axis_tdata[KEY_W +: WORD_W];
    assign in_detail = s_axis_tdata[KEY_W+WORD_W +: WORD_W];
    assign in_op     = t_op'(s_axis_tuser);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_bad    = (in_key == '0) || (in_op == OP_RSVD);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state            r_state, n_state;
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [WORD_W-1:0] r_name;
    logic [WORD_W-1:0] r_detail;

    // probe walker: position, odd increment mod N, probes issued
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_inc;
    logic [IDX_W:0]    r_cnt;

    // read/compare stage
    logic              r_cmp_vld;
    logic              r_cmp_last;
    logic [IDX_W-1:0]  r_cmp_addr;
    logic [KEY_W-1:0]  r_rd_key;
    logic              r_rd_vld;

    t_status           r_status;
    logic [SLOT_W-1:0] r_slot;

    logic              r_out_vld;
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_slot;

    // key store with per-slot valid; payload store is write-only here
    logic [KEY_W-1:0]    mem_key [TABLE_SIZE];
    logic [2*WORD_W-1:0] mem_pay [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_key_vld;

    // ---------------------------------------------------------------
    // residue unit
    // ---------------------------------------------------------------
    logic             mod_start;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;

    qpht_mod_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (in_key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // ---------------------------------------------------------------
    // compare
    // ---------------------------------------------------------------
    logic [KEY_W-1:0] eff_key;
    logic [KEY_W-1:0] want_key;
    logic             hit;
    logic             miss_end;

    assign eff_key  = r_rd_vld ? r_rd_key : '0;
    assign want_key = (r_op == OP_INSERT) ? '0 : r_key;
    assign hit      = r_cmp_vld && (eff_key == want_key);
    assign miss_end = r_cmp_vld && !hit && r_cmp_last;

    // next probe position: pos + inc, inc + 2, both mod N
    logic [IDX_W:0]   pos_sum;
    logic [IDX_W:0]   inc_sum;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] inc_next;

    always_comb begin
        pos_sum  = {1'b0, r_pos} + {1'b0, r_inc};
        inc_sum  = {1'b0, r_inc} + (IDX_W+1)'(2);
        pos_next = (pos_sum >= N_C) ? IDX_W'(pos_sum - N_C) : pos_sum[IDX_W-1:0];
        inc_next = (inc_sum >= N_C) ? IDX_W'(inc_sum - N_C) : inc_sum[IDX_W-1:0];
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    logic out_free;
    assign out_free = !r_out_vld || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = in_bad ? ST_FINISH : ST_HASH;
                end
            end
            ST_HASH: begin
                if (mod_done) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (hit || miss_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    logic issue;
    logic wr_en;
    logic post;

    always_comb begin
        s_axis_tready = 1'b0;
        mod_start     = 1'b0;
        issue         = 1'b0;
        wr_en         = 1'b0;
        post          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mod_start     = s_axis_tvalid && !in_bad;
            end
            ST_HASH: begin
            end
            ST_PROBE: begin
                wr_en = hit;
                issue = !hit && !miss_end && (r_cnt != N_C);
            end
            ST_FINISH: begin
                post = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // request latch, walker, status
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= in_op;
            r_key    <= in_key;
            r_name   <= in_name;
            r_detail <= in_detail;
        end
        if (r_state == ST_HASH && mod_done) begin
            r_pos <= mod_rem;
            r_inc <= D_INIT;
            r_cnt <= '0;
        end else if (issue) begin
            r_pos <= pos_next;
            r_inc <= inc_next;
            r_cnt <= r_cnt + 1'b1;
        end
        if (issue) begin
            r_cmp_addr <= r_pos;
            r_cmp_last <= (r_cnt == CNT_LAST);
            r_rd_key   <= mem_key[r_pos];
            r_rd_vld   <= r_key_vld[r_pos];
        end
        priority if (in_accept && in_bad) begin
            r_status <= STS_BAD;
            r_slot   <= '0;
        end else if (r_state == ST_PROBE && hit) begin
            r_slot <= SLOT_W'(r_cmp_addr);
            unique case (r_op)
                OP_INSERT: r_status <= STS_INSERTED;
                OP_UPDATE: r_status <= STS_UPDATED;
                OP_DELETE: r_status <= STS_DELETED;
                default:   r_status <= STS_BAD;
            endcase
        end else if (r_state == ST_PROBE && miss_end) begin
            r_slot   <= '0;
            r_status <= (r_op == OP_INSERT) ? STS_FULL : STS_NOT_FOUND;
        end
        if (post) begin
            r_out_status <= r_status;
            r_out_slot   <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= issue;
            if (post) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // table stores
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_op == OP_INSERT) begin
                mem_key[r_cmp_addr] <= r_key;
            end
            if (r_op == OP_DELETE) begin
                mem_pay[r_cmp_addr] <= '0;
            end else begin
                mem_pay[r_cmp_addr] <= {r_detail, r_name};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
        end else if (wr_en) begin
            if (r_op == OP_INSERT) begin
                r_key_vld[r_cmp_addr] <= 1'b1;
            end else if (r_op == OP_DELETE) begin
                r_key_vld[r_cmp_addr] <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result port
    // ---------------------------------------------------------------
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W-STATUS_W-SLOT_W)'(0), r_out_slot, r_out_status};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    logic bad_accept;
    logic out_no_slot;
    logic bad_posted;

    assign bad_accept  = in_accept && in_bad;
    assign bad_posted  = (r_state == ST_FINISH) && (r_status == STS_BAD);
    assign out_no_slot = m_axis_tvalid && (r_out_status == STS_FULL ||
                         r_out_status == STS_NOT_FOUND || r_out_status == STS_BAD);

    `QPHT_ASSERT_NEXT(a_bad_req_status, i_clk, i_rst_n, bad_accept, bad_posted)
    `QPHT_ASSERT_NOW(a_fail_slot_zero, i_clk, i_rst_n, out_no_slot, r_out_slot == '0)
    `QPHT_ASSERT_NOW(a_cmp_only_probing, i_clk, i_rst_n, r_cmp_vld, r_state == ST_PROBE)

endmodule
`default_nettype wire
